### rtl/spa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package spa_pkg;

  // Number formats
  localparam int FRAC_BITS      = 22;
  localparam int COEF_FRAC_BITS = 30;
  localparam int TAB_FRAC       = 40;
  localparam int ANGLE_W        = 24;
  localparam int SINE_W         = 24;
  localparam int COEF_W         = 32;

  // z = x*x carries COEF_FRAC_BITS fraction bits
  localparam int ZSH    = 2 * FRAC_BITS - COEF_FRAC_BITS;
  localparam int SQ_W   = 2 * ANGLE_W;
  localparam int Z_W    = SQ_W - 1 - ZSH;
  // acc * z product, and x * acc product
  localparam int PROD_W = COEF_W + Z_W + 1;
  localparam int YP_W   = ANGLE_W + COEF_W;
  localparam int YS_W   = YP_W - COEF_FRAC_BITS;

  // Rounding offsets (half an LSB of the kept part)
  localparam logic [SQ_W-1:0]   Z_RND = SQ_W'(1) << (ZSH - 1);
  localparam logic [PROD_W-1:0] P_RND = PROD_W'(1) << (COEF_FRAC_BITS - 1);
  localparam logic [YP_W-1:0]   Y_RND = YP_W'(1) << (COEF_FRAC_BITS - 1);

  // |x| > pi/4 threshold, pi/4 scaled by 2^40
  localparam longint PI4_Q40 = 64'sd863554413085;
  localparam longint PI4_LIM = PI4_Q40 >>> (TAB_FRAC - FRAC_BITS);

  // Polynomial select
  typedef enum logic [1:0] {
    MODE_DEG5     = 2'd0,
    MODE_DEG7     = 2'd1,
    MODE_DEG7_ALT = 2'd2,
    MODE_DEG9     = 2'd3
  } poly_mode_t;

  localparam poly_mode_t MODE_RESET = MODE_DEG7;

  // Horner steps after the leading coefficient
  localparam int NCOEF  = 5;
  localparam int NSTEPS = NCOEF - 1;

  localparam longint ONE_Q40 = 64'sd1 << TAB_FRAC;

  // Coefficients scaled by 2^40, highest degree first, zero-padded at the
  // front so every set runs through the same number of Horner steps.
  localparam longint COEF_Q40 [4][NCOEF] = '{
    '{64'sd0, 64'sd0,
      longint'(64'h10B10DA << 9), -longint'(64'h1553EEE << 13),
      longint'(64'h1FFFFCE << 15)},
    '{64'sd0, -longint'(64'h1992CF8 << 3), longint'(64'h11106E6 << 9),
      -longint'(64'h1555544 << 13), ONE_Q40},
    '{64'sd0, -64'sd214572948, 64'sd9161307765, -64'sd183251805409, ONE_Q40},
    '{longint'(64'h2EFC42), -longint'(64'h1A04866 << 3),
      longint'(64'h1111164 << 9), -longint'(64'h1555556 << 13), ONE_Q40}
  };

  // Coefficient in COEF_FRAC_BITS fraction, rounded to nearest, ties away
  function automatic logic signed [COEF_W-1:0] coef_at(input poly_mode_t mode,
                                                        input int idx);
    longint v;
    longint m;
    v = COEF_Q40[mode][idx];
    m = (v < 0) ? -v : v;
    m = (m >>> (TAB_FRAC - COEF_FRAC_BITS)) +
        ((m >>> (TAB_FRAC - COEF_FRAC_BITS - 1)) & 64'sd1);
    return COEF_W'((v < 0) ? -m : m);
  endfunction

endpackage

`default_nettype wire

### rtl/sine_polynomial_approx.sv
`timescale 1ns / 1ps
`default_nettype none

// Sine of a reduced-range angle by an odd minimax polynomial. Each input word
// is one angle in radians, signed Q2.22, meant for -pi/4..pi/4; each output
// word is the sine in signed Q2.22, saturated, with tuser set when the angle
// magnitude exceeds pi/4 (the value is still computed, just less accurate).
// cfg_wr_data picks the polynomial: 0 degree 5, 1 degree 7 (reset), 2 the
// alternate degree-7 set, 3 degree 9; write it only while the pipeline is
// empty. The datapath is a 12-stage pipeline: input register, z = x*x, four
// Horner steps of one multiply stage and one round-and-add stage each, then
// the final multiply by x and a round-and-saturate output register. One word
// is taken every cycle; each stage has its own valid bit, so a stall on the
// output fills bubbles before it blocks input.
module sine_polynomial_approx
  import spa_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [1:0]        cfg_wr_data,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [23:0]       s_tdata,   // [23:0] angle
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [23:0]       m_tdata,   // [23:0] sine_value
  output logic              m_tuser    // [0] range_flag
);

  localparam int NST    = 12;
  localparam int ST_Z   = 1;
  localparam int ST_YP  = 2 * NSTEPS + 2;
  localparam int ST_OUT = NST - 1;

  poly_mode_t poly_mode;

  logic [NST-1:0] vld;
  logic [NST-1:0] adv;

  logic signed [ANGLE_W-1:0] x_q    [0:ST_YP-1];
  poly_mode_t                mode_q [0:2*NSTEPS];
  logic [Z_W-1:0]            z_q    [ST_Z:2*NSTEPS-1];
  logic                      flag_q [ST_Z:ST_OUT];
  logic signed [COEF_W-1:0]  acc_q  [0:NSTEPS];
  logic signed [PROD_W-1:0]  prod_q [1:NSTEPS];
  logic signed [YP_W-1:0]    y_prod;
  logic [SINE_W-1:0]         sine_q;

  logic signed [SQ_W-1:0]    sq;
  logic [SQ_W-1:0]           sq_rnd;
  logic [Z_W-1:0]            z_next;
  logic [ANGLE_W-1:0]        ax;
  logic                      flag_next;
  logic [PROD_W-1:0]         rnd    [1:NSTEPS];
  logic signed [COEF_W-1:0]  acc_next [1:NSTEPS];
  logic [YP_W-1:0]           y_rnd;
  logic [YS_W-1:0]           y_sh;
  logic [SINE_W-1:0]         sine_next;

  // Hold the polynomial select
  always_ff @(posedge clk) begin
    if (rst) begin
      poly_mode <= MODE_RESET;
    end else if (cfg_wr_en) begin
      poly_mode <= poly_mode_t'(cfg_wr_data);
    end
  end

  // Advance a stage when it is empty or the next one advances
  always_comb begin
    adv[NST-1] = !vld[NST-1] || m_tready;
    for (int i = NST - 2; i >= 0; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  assign s_tready = adv[0];

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= s_tvalid;
      for (int i = 1; i < NST; i++) begin
        if (adv[i]) vld[i] <= vld[i-1];
      end
    end
  end

  // Square, range check, Horner rounding and output round-and-saturate
  always_comb begin
    sq        = x_q[0] * x_q[0];
    sq_rnd    = sq + Z_RND;
    z_next    = sq_rnd[ZSH+Z_W-1:ZSH];
    ax        = x_q[0][ANGLE_W-1] ? ANGLE_W'(-x_q[0]) : ANGLE_W'(x_q[0]);
    flag_next = ax > ANGLE_W'(PI4_LIM);
    for (int k = 1; k <= NSTEPS; k++) begin
      rnd[k]      = prod_q[k] + P_RND - PROD_W'(prod_q[k][PROD_W-1]);
      acc_next[k] = $signed(rnd[k][COEF_FRAC_BITS+COEF_W-1:COEF_FRAC_BITS]) +
                    coef_at(mode_q[2*k], k);
    end
    y_rnd = y_prod + Y_RND - YP_W'(y_prod[YP_W-1]);
    y_sh  = y_rnd[YP_W-1:COEF_FRAC_BITS];
    // saturate to the output range
    if ((&y_sh[YS_W-1:SINE_W-1]) || !(|y_sh[YS_W-1:SINE_W-1])) begin
      sine_next = y_sh[SINE_W-1:0];
    end else if (y_sh[YS_W-1]) begin
      sine_next = {1'b1, {(SINE_W-1){1'b0}}};
    end else begin
      sine_next = {1'b0, {(SINE_W-1){1'b1}}};
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      x_q[0]    <= $signed(s_tdata[ANGLE_W-1:0]);
      mode_q[0] <= poly_mode;
    end
    if (adv[ST_Z]) begin
      z_q[ST_Z]    <= z_next;
      flag_q[ST_Z] <= flag_next;
      acc_q[0]     <= coef_at(mode_q[0], 0);
    end
    for (int i = 1; i <= ST_YP - 1; i++) begin
      if (adv[i]) x_q[i] <= x_q[i-1];
    end
    for (int i = 1; i <= 2 * NSTEPS; i++) begin
      if (adv[i]) mode_q[i] <= mode_q[i-1];
    end
    for (int i = ST_Z + 1; i <= 2 * NSTEPS - 1; i++) begin
      if (adv[i]) z_q[i] <= z_q[i-1];
    end
    for (int i = ST_Z + 1; i <= ST_OUT; i++) begin
      if (adv[i]) flag_q[i] <= flag_q[i-1];
    end
    // Horner step k: multiply at stage 2k, round and add at stage 2k+1
    for (int k = 1; k <= NSTEPS; k++) begin
      if (adv[2*k])   prod_q[k] <= acc_q[k-1] * $signed({1'b0, z_q[2*k-1]});
      if (adv[2*k+1]) acc_q[k]  <= acc_next[k];
    end
    if (adv[ST_YP])  y_prod <= x_q[ST_YP-1] * acc_q[NSTEPS];
    if (adv[ST_OUT]) sine_q <= sine_next;
  end

  assign m_tvalid = vld[ST_OUT];
  assign m_tdata  = sine_q;
  assign m_tuser  = flag_q[ST_OUT];

endmodule

`default_nettype wire

### rtl/spa_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module spa_checker
  import spa_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic        m_tuser
);

  // In-range angles give |sin| just above sin(pi/4) at most
  localparam logic [SINE_W-1:0] IN_RANGE_MAX = SINE_W'(3000000);

  logic [SINE_W-1:0] sine_mag;

  assign sine_mag = m_tdata[SINE_W-1] ? SINE_W'(-m_tdata) : m_tdata;

  // Hold a stalled output word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output word changed while stalled");

  // Take input whenever the output side can drain
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    (!m_tvalid || m_tready) |-> s_tready)
    else $error("input stalled with output free");

  // Drop all words on reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // In-range results stay near the unit-circle bound
  a_in_range_mag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> sine_mag <= IN_RANGE_MAX)
    else $error("in-range result too large");

endmodule

bind sine_polynomial_approx spa_checker u_spa_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire
